FILE: hdl/tftpc_pkg.sv
// ----------------------------------------------------------------------------
// tftpc_pkg
// types and codes shared by the tftp client transfer engine modules
// ----------------------------------------------------------------------------
package tftpc_pkg;

    // transfer phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_READ   = 3'd1,
        PH_WACK0  = 3'd2,
        PH_WFETCH = 3'd3,
        PH_WACK   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // event kinds
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_PACKET  = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_BLOCK   = 2'd3;

    // received opcodes
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    // packet to send
    localparam logic [2:0] SEND_NONE = 3'd0;
    localparam logic [2:0] SEND_REQ  = 3'd1;
    localparam logic [2:0] SEND_ACK  = 3'd2;
    localparam logic [2:0] SEND_DATA = 3'd3;
    localparam logic [2:0] SEND_ERR  = 3'd4;

    // status
    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_SERVER  = 3'd2;
    localparam logic [2:0] ST_UNEXP   = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_DUPS    = 3'd5;

    // error message select
    localparam logic [1:0] TXT_NONE    = 2'd0;
    localparam logic [1:0] TXT_DUPS    = 2'd1;
    localparam logic [1:0] TXT_NO_ACK0 = 2'd2;
    localparam logic [1:0] TXT_NO_ACK  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DIRECTION   = 2'd0;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [1:0] CFG_DUP_LIMIT   = 2'd2;

    // counter saturation
    localparam logic [3:0] CNT_MAX = 4'd15;

    typedef struct packed {
        logic       direction;
        logic [3:0] max_retries;
        logic [3:0] dup_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [9:0]  payload_len;
        logic [15:0] error_code;
    } evt_t;

    typedef struct packed {
        logic [2:0]  send_kind;
        logic [15:0] send_block;
        logic [9:0]  send_len;
        logic        store_payload;
        logic        fetch_block;
        logic [2:0]  status;
        logic [15:0] server_code;
        logic [1:0]  error_text_sel;
    } res_t;

endpackage

FILE: hdl/tftpc_in_stage.sv
// ----------------------------------------------------------------------------
// tftpc_in_stage
// input register: holds one event until the engine takes it
// ----------------------------------------------------------------------------
module tftpc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tftpc_pkg::evt_t   evt_in,
    input  logic              take,
    output logic              evt_vld,
    output tftpc_pkg::evt_t   evt_out
);

    logic            vld_reg;
    logic            vld_next;
    tftpc_pkg::evt_t evt_reg;

    assign in_ready = !vld_reg || take;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            evt_reg <= evt_in;
        end
    end

    assign evt_vld = vld_reg;
    assign evt_out = evt_reg;

endmodule

FILE: hdl/tftpc_fsm.sv
// ----------------------------------------------------------------------------
// tftpc_fsm
// transfer state and one-event decision logic
// ----------------------------------------------------------------------------
module tftpc_fsm #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_go,
    input  tftpc_pkg::evt_t   evt,
    input  tftpc_pkg::cfg_t   cfg,
    output tftpc_pkg::res_t   res
);

    localparam logic [16:0] BLOCK_LIMIT = 17'(BLOCK_BYTES);

    tftpc_pkg::phase_t phase_reg;
    tftpc_pkg::phase_t phase_next;
    logic [15:0] exp_blk_reg;
    logic [15:0] exp_blk_next;
    logic [15:0] last_blk_reg;
    logic [15:0] last_blk_next;
    logic [3:0]  dup_cnt_reg;
    logic [3:0]  dup_cnt_next;
    logic [3:0]  to_cnt_reg;
    logic [3:0]  to_cnt_next;
    logic [15:0] snd_blk_reg;
    logic [15:0] snd_blk_next;
    logic [9:0]  snd_len_reg;
    logic [9:0]  snd_len_next;

    logic [3:0] to_inc;
    logic [3:0] dup_inc;
    logic       to_hit;
    logic       dup_hit;
    logic       is_short;
    logic       full_block;
    logic       match_exp;
    logic       match_last;
    logic       read_ack;
    logic       is_start;
    logic       is_packet;
    logic       is_timeout;
    logic       is_block;

    // shared decode
    assign to_inc     = (to_cnt_reg < tftpc_pkg::CNT_MAX) ? to_cnt_reg + 4'd1 : to_cnt_reg;
    assign dup_inc    = (dup_cnt_reg < tftpc_pkg::CNT_MAX) ? dup_cnt_reg + 4'd1 : dup_cnt_reg;
    assign to_hit     = to_inc >= cfg.max_retries;
    assign dup_hit    = dup_inc >= cfg.dup_limit;
    assign is_short   = {7'd0, evt.payload_len} < BLOCK_LIMIT;
    assign full_block = {7'd0, snd_len_reg} == BLOCK_LIMIT;
    assign match_exp  = evt.block_number == exp_blk_reg;
    assign match_last = evt.block_number == last_blk_reg;
    assign read_ack   = match_exp || (match_last && !dup_hit);
    assign is_start   = evt.req_type == tftpc_pkg::REQ_START;
    assign is_packet  = evt.req_type == tftpc_pkg::REQ_PACKET;
    assign is_timeout = evt.req_type == tftpc_pkg::REQ_TIMEOUT;
    assign is_block   = evt.req_type == tftpc_pkg::REQ_BLOCK;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_start)
        begin
            phase_next = cfg.direction ? tftpc_pkg::PH_WACK0 : tftpc_pkg::PH_READ;
        end
        else
        begin
            case (phase_reg)
                tftpc_pkg::PH_READ:
                begin
                    if (is_timeout && to_hit)
                    begin
                        phase_next = tftpc_pkg::PH_DONE;
                    end
                    else if (is_packet)
                    begin
                        if (evt.opcode != tftpc_pkg::OP_DATA)
                        begin
                            phase_next = tftpc_pkg::PH_DONE;
                        end
                        else if (read_ack && is_short)
                        begin
                            phase_next = tftpc_pkg::PH_DONE;
                        end
                        else if (!match_exp && match_last && dup_hit)
                        begin
                            phase_next = tftpc_pkg::PH_DONE;
                        end
                    end
                end
                tftpc_pkg::PH_WACK0:
                begin
                    if (is_timeout && to_hit)
                    begin
                        phase_next = tftpc_pkg::PH_DONE;
                    end
                    else if (is_packet && evt.opcode == tftpc_pkg::OP_ERROR)
                    begin
                        phase_next = tftpc_pkg::PH_DONE;
                    end
                    else if (is_packet && evt.opcode == tftpc_pkg::OP_ACK
                             && evt.block_number == 16'd0)
                    begin
                        phase_next = tftpc_pkg::PH_WFETCH;
                    end
                end
                tftpc_pkg::PH_WFETCH:
                begin
                    if (is_block)
                    begin
                        phase_next = tftpc_pkg::PH_WACK;
                    end
                end
                tftpc_pkg::PH_WACK:
                begin
                    if (is_timeout && to_hit)
                    begin
                        phase_next = tftpc_pkg::PH_DONE;
                    end
                    else if (is_packet && evt.opcode == tftpc_pkg::OP_ERROR)
                    begin
                        phase_next = tftpc_pkg::PH_DONE;
                    end
                    else if (is_packet && evt.opcode == tftpc_pkg::OP_ACK
                             && evt.block_number == snd_blk_reg)
                    begin
                        phase_next = full_block ? tftpc_pkg::PH_WFETCH : tftpc_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result and datapath updates
    always_comb
    begin
        res          = '0;
        exp_blk_next  = exp_blk_reg;
        last_blk_next = last_blk_reg;
        dup_cnt_next  = dup_cnt_reg;
        to_cnt_next   = to_cnt_reg;
        snd_blk_next  = snd_blk_reg;
        snd_len_next  = snd_len_reg;
        if (is_start)
        begin
            exp_blk_next  = 16'd1;
            last_blk_next = 16'd0;
            dup_cnt_next  = 4'd0;
            to_cnt_next   = 4'd0;
            snd_blk_next  = 16'd1;
            snd_len_next  = 10'd0;
            res.send_kind = tftpc_pkg::SEND_REQ;
        end
        else
        begin
            case (phase_reg)
                tftpc_pkg::PH_READ:
                begin
                    if (is_timeout)
                    begin
                        to_cnt_next = to_inc;
                        if (to_hit)
                        begin
                            res.status = tftpc_pkg::ST_TIMEOUT;
                        end
                    end
                    else if (is_packet)
                    begin
                        to_cnt_next = 4'd0;
                        if (evt.opcode == tftpc_pkg::OP_ERROR)
                        begin
                            res.status      = tftpc_pkg::ST_SERVER;
                            res.server_code = evt.error_code;
                        end
                        else if (evt.opcode != tftpc_pkg::OP_DATA)
                        begin
                            res.status = tftpc_pkg::ST_UNEXP;
                        end
                        else
                        begin
                            if (match_exp)
                            begin
                                res.store_payload = 1'b1;
                                exp_blk_next      = exp_blk_reg + 16'd1;
                                dup_cnt_next      = 4'd0;
                            end
                            else if (match_last)
                            begin
                                dup_cnt_next = dup_inc;
                                if (dup_hit)
                                begin
                                    res.send_kind      = tftpc_pkg::SEND_ERR;
                                    res.error_text_sel = tftpc_pkg::TXT_DUPS;
                                    res.status         = tftpc_pkg::ST_DUPS;
                                end
                            end
                            if (read_ack)
                            begin
                                res.send_kind  = tftpc_pkg::SEND_ACK;
                                res.send_block = evt.block_number;
                                last_blk_next  = evt.block_number;
                                if (is_short)
                                begin
                                    res.status = tftpc_pkg::ST_DONE;
                                end
                            end
                        end
                    end
                end
                tftpc_pkg::PH_WACK0:
                begin
                    if (is_timeout)
                    begin
                        to_cnt_next = to_inc;
                        if (to_hit)
                        begin
                            res.send_kind      = tftpc_pkg::SEND_ERR;
                            res.error_text_sel = tftpc_pkg::TXT_NO_ACK0;
                            res.status         = tftpc_pkg::ST_TIMEOUT;
                        end
                    end
                    else if (is_packet)
                    begin
                        if (evt.opcode == tftpc_pkg::OP_ERROR)
                        begin
                            res.status      = tftpc_pkg::ST_SERVER;
                            res.server_code = evt.error_code;
                        end
                        else if (evt.opcode == tftpc_pkg::OP_ACK && evt.block_number == 16'd0)
                        begin
                            res.fetch_block = 1'b1;
                            snd_blk_next    = 16'd1;
                        end
                    end
                end
                tftpc_pkg::PH_WFETCH:
                begin
                    if (is_block)
                    begin
                        snd_len_next   = evt.payload_len;
                        to_cnt_next    = 4'd0;
                        res.send_kind  = tftpc_pkg::SEND_DATA;
                        res.send_block = snd_blk_reg;
                        res.send_len   = evt.payload_len;
                    end
                end
                tftpc_pkg::PH_WACK:
                begin
                    if (is_timeout)
                    begin
                        to_cnt_next = to_inc;
                        if (to_hit)
                        begin
                            res.send_kind      = tftpc_pkg::SEND_ERR;
                            res.error_text_sel = tftpc_pkg::TXT_NO_ACK;
                            res.status         = tftpc_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            res.send_kind  = tftpc_pkg::SEND_DATA;
                            res.send_block = snd_blk_reg;
                            res.send_len   = snd_len_reg;
                        end
                    end
                    else if (is_packet)
                    begin
                        if (evt.opcode == tftpc_pkg::OP_ERROR)
                        begin
                            res.status      = tftpc_pkg::ST_SERVER;
                            res.server_code = evt.error_code;
                        end
                        else if (evt.opcode == tftpc_pkg::OP_ACK
                                 && evt.block_number == snd_blk_reg)
                        begin
                            if (full_block)
                            begin
                                snd_blk_next    = snd_blk_reg + 16'd1;
                                res.fetch_block = 1'b1;
                            end
                            else
                            begin
                                res.status = tftpc_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            // wrong ack or stray packet: resend the block
                            res.send_kind  = tftpc_pkg::SEND_DATA;
                            res.send_block = snd_blk_reg;
                            res.send_len   = snd_len_reg;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tftpc_pkg::PH_IDLE;
            exp_blk_reg  <= 16'd1;
            last_blk_reg <= 16'd0;
            dup_cnt_reg  <= 4'd0;
            to_cnt_reg   <= 4'd0;
            snd_blk_reg  <= 16'd1;
            snd_len_reg  <= 10'd0;
        end
        else if (evt_go)
        begin
            phase_reg    <= phase_next;
            exp_blk_reg  <= exp_blk_next;
            last_blk_reg <= last_blk_next;
            dup_cnt_reg  <= dup_cnt_next;
            to_cnt_reg   <= to_cnt_next;
            snd_blk_reg  <= snd_blk_next;
            snd_len_reg  <= snd_len_next;
        end
    end

endmodule

FILE: hdl/tftpc_out_stage.sv
// ----------------------------------------------------------------------------
// tftpc_out_stage
// result register: holds one result item until the sink takes it
// ----------------------------------------------------------------------------
module tftpc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tftpc_pkg::res_t   res_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output tftpc_pkg::res_t   res_out
);

    logic            vld_reg;
    logic            vld_next;
    tftpc_pkg::res_t res_reg;

    assign can_load = !vld_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = vld_reg;
    assign res_out   = res_reg;

endmodule

FILE: hdl/tftp_client_transfer_engine_core.sv
// ----------------------------------------------------------------------------
// tftp_client_transfer_engine_core
// path: an accepted input item waits in the input register, then its result is loaded into the result register
// throughput: one item per cycle while the sink takes every result, set by the combinational
//   decision logic between the input register and the result register
// reset: async active low; phase idle, block counters at start values,
//   config back to direction 0, max_retries 3, dup_limit 3
// ----------------------------------------------------------------------------
module tftp_client_transfer_engine_core #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,

    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,

    // event item in
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] opcode,
    input  logic [15:0] block_number,
    input  logic [9:0]  payload_len,
    input  logic [15:0] error_code,

    // result item out
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  send_kind,
    output logic [15:0] send_block,
    output logic [9:0]  send_len,
    output logic        store_payload,
    output logic        fetch_block,
    output logic [2:0]  status,
    output logic [15:0] server_code,
    output logic [1:0]  error_text_sel
);

    tftpc_pkg::cfg_t cfg_reg;
    tftpc_pkg::cfg_t cfg_next;
    tftpc_pkg::evt_t evt_in;
    tftpc_pkg::evt_t evt_q;
    tftpc_pkg::res_t res_c;
    tftpc_pkg::res_t res_q;
    logic            evt_vld;
    logic            can_load;
    logic            advance;

    // ------------------------------------------------------------------
    // config registers, always ready; unknown index is dropped
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tftpc_pkg::CFG_DIRECTION:   cfg_next.direction   = cfg_data[0];
                tftpc_pkg::CFG_MAX_RETRIES: cfg_next.max_retries = cfg_data;
                tftpc_pkg::CFG_DUP_LIMIT:   cfg_next.dup_limit   = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{direction: 1'b0, max_retries: 4'd3, dup_limit: 4'd3};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    assign evt_in = '{req_type:     req_type,
                      opcode:       opcode,
                      block_number: block_number,
                      payload_len:  payload_len,
                      error_code:   error_code};

    // an event is processed when the result register has room for it
    assign advance = evt_vld && can_load;

    tftpc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .evt_in   (evt_in),
        .take     (advance),
        .evt_vld  (evt_vld),
        .evt_out  (evt_q)
    );

    // ------------------------------------------------------------------
    // transfer state and decision logic, state moves only on advance
    // ------------------------------------------------------------------
    tftpc_fsm #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt_go (advance),
        .evt    (evt_q),
        .cfg    (cfg_reg),
        .res    (res_c)
    );

    // ------------------------------------------------------------------
    // result register, frees itself in the same cycle the sink takes it
    // ------------------------------------------------------------------
    tftpc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_c),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_q)
    );

    assign send_kind      = res_q.send_kind;
    assign send_block     = res_q.send_block;
    assign send_len       = res_q.send_len;
    assign store_payload  = res_q.store_payload;
    assign fetch_block    = res_q.fetch_block;
    assign status         = res_q.status;
    assign server_code    = res_q.server_code;
    assign error_text_sel = res_q.error_text_sel;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a processed event always shows up as a result item next cycle
    a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed event did not produce a result item");

    // stored payload only goes with an ack of that block
    a_store_acks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && store_payload) |-> (send_kind == tftpc_pkg::SEND_ACK))
        else $error("payload stored without an ack");

    // an error packet sent always carries a message select
    a_err_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_kind == tftpc_pkg::SEND_ERR)
            |-> (error_text_sel != tftpc_pkg::TXT_NONE))
        else $error("error packet without message select");

    // server error ends the transfer without sending anything
    a_server_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tftpc_pkg::ST_SERVER)
            |-> (send_kind == tftpc_pkg::SEND_NONE))
        else $error("packet sent on server error");

endmodule
